// ===== sv/ift_pkg.sv =====
// ----------------------------------------------------------------------------
// ift_pkg
// Shared types, constants and helpers of the inertial fling tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ift_pkg;

  localparam int VEL_W  = 23;
  localparam int PROD_W = 62;
  localparam int SSQ_W  = 60;
  localparam int DIVN_W = 43;
  localparam int DIVD_W = 22;
  localparam int RAD_W  = 44;
  localparam int OUT_W  = 24;

  localparam logic signed [VEL_W-1:0] VEL_SAT = 23'sd2097152;
  localparam logic signed [PROD_W-1:0] OUT_MAX = 62'sd8388607;
  localparam logic signed [PROD_W-1:0] OUT_MIN = -62'sd8388608;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_MOVE    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_TICK    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_EMA_WEIGHT    = 3'd0,
    REG_FRICTION      = 3'd1,
    REG_MIN_SPEED     = 3'd2,
    REG_CAP_SPEED     = 3'd3,
    REG_TICK_MS       = 3'd4,
    REG_MAX_GAP_MS    = 3'd5,
    REG_PAUSE_MS      = 3'd6,
    REG_STOP_DISTANCE = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [8:0]  ema_weight;
    logic [8:0]  friction_factor;
    logic [18:0] min_speed;
    logic [18:0] cap_speed;
    logic [7:0]  tick_ms;
    logic [15:0] max_gap_ms;
    logic [15:0] pause_ms;
    logic [16:0] stop_distance;
  } cfg_t;

  // Multiplier operand selection.
  typedef enum logic [3:0] {
    MOP_NONE,
    MOP_INST_W,
    MOP_V_WC,
    MOP_V_V,
    MOP_MIN,
    MOP_CAP2,
    MOP_V_CAP,
    MOP_V_TK,
    MOP_V_F,
    MOP_D_D,
    MOP_SD
  } mop_t;

  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_PRESS,
    ACT_SET_LAST,
    ACT_DIV_MOVE,
    ACT_INST,
    ACT_EMA,
    ACT_REL,
    ACT_SSQ,
    ACT_CMP_MIN,
    ACT_CMP_CAP,
    ACT_SQRT,
    ACT_DIV_CAP,
    ACT_VCAP,
    ACT_GLIDE_ON,
    ACT_GLIDE_OFF,
    ACT_OUTD,
    ACT_FRIC,
    ACT_DIST,
    ACT_CMP_STOP
  } act_t;

  typedef enum logic {
    ACC_HOLD,
    ACC_LOAD
  } acc_t;

  typedef enum logic {
    LANE_X = 1'b0,
    LANE_Y = 1'b1
  } lane_t;

  typedef struct packed {
    mop_t  mop;
    lane_t mlane;
    acc_t  acc;
    act_t  act;
    lane_t alane;
    logic  done;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic drag;
    logic glide;
    logic left;
    logic shift;
    logic map;
    logic gap_ok;
    logic above_min;
    logic above_cap;
    logic div_busy;
    logic sqrt_busy;
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE,
    S_DISPATCH,
    S_MV_DIVX,
    S_MV_WX,
    S_MV_DIVY,
    S_MV_WY,
    S_MV_E0,
    S_MV_E1,
    S_MV_E2,
    S_MV_E3,
    S_MV_E4,
    S_MV_E5,
    S_RL_0,
    S_RL_1,
    S_RL_2,
    S_RL_3,
    S_RL_4,
    S_RL_5,
    S_RL_SQW,
    S_RL_C0,
    S_RL_C1,
    S_RL_C2,
    S_RL_C3,
    S_RL_C4,
    S_RL_C5,
    S_RL_C6,
    S_TK_0,
    S_TK_1,
    S_TK_2,
    S_TK_3,
    S_TK_4,
    S_TK_5,
    S_TK_6,
    S_TK_7,
    S_TK_8,
    S_TK_9,
    S_TK_10,
    S_TK_11,
    S_FIN
  } st_t;

  // Divide by 256 with truncation toward zero.
  function automatic logic signed [VEL_W-1:0] div256_tz(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] a;
    a = x + (x[PROD_W-1] ? 62'sd255 : 62'sd0);
    return a[VEL_W+7:8];
  endfunction

  function automatic logic [8:0] clamp256(input logic [8:0] v);
    return (v > 9'd256) ? 9'd256 : v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ift_in_if.sv =====
// ----------------------------------------------------------------------------
// ift_in_if
// Input event channel: valid/ready handshake with one pointer or tick event.
// ----------------------------------------------------------------------------
`default_nettype none

interface ift_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [19:0] pos_x;
  logic signed [19:0] pos_y;
  logic [31:0]        time_ms;
  logic               left_button;
  logic               shift_held;
  logic               map_present;

  modport source (output valid, operation, pos_x, pos_y, time_ms, left_button,
                  shift_held, map_present, input ready);
  modport sink (input valid, operation, pos_x, pos_y, time_ms, left_button,
                shift_held, map_present, output ready);
endinterface

`default_nettype wire

// ===== sv/ift_out_if.sv =====
// ----------------------------------------------------------------------------
// ift_out_if
// Result channel: valid/ready handshake with one pan result per event.
// ----------------------------------------------------------------------------
`default_nettype none

interface ift_out_if;
  logic               valid;
  logic               ready;
  logic               move_valid;
  logic signed [23:0] move_dx;
  logic signed [23:0] move_dy;
  logic               gliding;

  modport source (output valid, move_valid, move_dx, move_dy, gliding, input ready);
  modport sink (input valid, move_valid, move_dx, move_dy, gliding, output ready);
endinterface

`default_nettype wire

// ===== sv/ift_divider.sv =====
// ----------------------------------------------------------------------------
// ift_divider
// Signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ift_divider
  import ift_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [DIVN_W-1:0] dividend,
  input  wire logic [DIVD_W-1:0]        divisor,
  output logic                          busy,
  output logic signed [DIVN_W-1:0]      quotient
);

  localparam logic [5:0] LAST_STEP = 6'(DIVN_W - 1);

  logic              busy_r;
  logic [5:0]        cnt_r;
  logic [DIVN_W-1:0] num_r;
  logic [DIVD_W:0]   rem_r;
  logic [DIVD_W-1:0] div_r;
  logic              neg_r;

  logic [DIVD_W:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem_r[DIVD_W-1:0], num_r[DIVN_W-1]};
  assign fits   = rem_sh >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= LAST_STEP;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend[DIVN_W-1] ? DIVN_W'(-dividend) : DIVN_W'(dividend);
      rem_r <= '0;
      div_r <= divisor;
      neg_r <= dividend[DIVN_W-1];
    end else if (busy_r) begin
      rem_r <= fits ? (rem_sh - {1'b0, div_r}) : rem_sh;
      num_r <= {num_r[DIVN_W-2:0], fits};
    end
  end

  assign busy     = busy_r;
  assign quotient = neg_r ? (DIVN_W'(0) - $signed(num_r)) : $signed(num_r);

endmodule

`default_nettype wire

// ===== sv/ift_sqrt.sv =====
// ----------------------------------------------------------------------------
// ift_sqrt
// Integer square root, floor, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ift_sqrt
  import ift_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [RAD_W-1:0] radicand,
  output logic                  busy,
  output logic [DIVD_W-1:0]     root
);

  localparam logic [4:0] LAST_STEP = 5'(RAD_W / 2 - 1);

  logic              busy_r;
  logic [4:0]        cnt_r;
  logic [RAD_W-1:0]  x_r;
  logic [DIVD_W+1:0] rem_r;
  logic [DIVD_W-1:0] root_r;

  logic [DIVD_W+3:0] rem_sh;
  logic [DIVD_W+3:0] trial;
  logic              fits;

  assign rem_sh = {rem_r, x_r[RAD_W-1:RAD_W-2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= LAST_STEP;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[RAD_W-3:0], 2'b00};
      rem_r  <= fits ? (DIVD_W+2)'(rem_sh - trial) : (DIVD_W+2)'(rem_sh);
      root_r <= {root_r[DIVD_W-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

`default_nettype wire

// ===== sv/ift_datapath.sv =====
// ----------------------------------------------------------------------------
// ift_datapath
// Tracker state, shared multiplier, divider and square root unit, driven
// step by step by the controller's commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ift_datapath
  import ift_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire cmd_t               cmd,
  input  wire logic [1:0]         operation,
  input  wire logic signed [19:0] pos_x,
  input  wire logic signed [19:0] pos_y,
  input  wire logic [31:0]        time_ms,
  input  wire logic               left_button,
  input  wire logic               shift_held,
  input  wire logic               map_present,
  output status_t                 status,
  output logic                    move_valid,
  output logic signed [OUT_W-1:0] move_dx,
  output logic signed [OUT_W-1:0] move_dy,
  output logic                    gliding
);

  // Latched event.
  op_t                op_r;
  logic signed [19:0] px_r, py_r;
  logic [31:0]        t_r;
  logic               left_r, shift_r, map_r;

  // Tracker state.
  logic               drag_r, glide_r;
  logic signed [19:0] lx_r, ly_r;
  logic [31:0]        lt_r;
  logic signed [VEL_W-1:0] vx_r, vy_r;

  // Working registers.
  logic signed [VEL_W-1:0]  inst_x_r, inst_y_r;
  logic signed [30:0]       dist_x_r, dist_y_r;
  logic signed [PROD_W-1:0] prod_r, acc_r;
  logic [SSQ_W-1:0]         ssq_r;
  logic                     above_min_r, above_cap_r;
  logic                     mv_r;
  logic signed [OUT_W-1:0]  dx_r, dy_r;

  logic [31:0]              dt;
  logic                     gap_ok, pause_exceed;
  logic [8:0]               w, wc, f;
  logic signed [VEL_W-1:0]  v_m, v_a, inst_m;
  logic signed [30:0]       dist_m;
  logic signed [30:0]       mul_a, mul_b;
  logic signed [PROD_W-1:0] sum_ap;
  logic signed [VEL_W-1:0]  ema_v, fric_v, inst_sat;
  logic signed [OUT_W-1:0]  outd;
  logic signed [20:0]       dpos;

  logic                     div_start, div_busy;
  logic signed [DIVN_W-1:0] div_num, div_q;
  logic [DIVD_W-1:0]        div_den;
  logic                     sqrt_start, sqrt_busy;
  logic [DIVD_W-1:0]        sqrt_root;

  assign dt           = t_r - lt_r;
  assign gap_ok       = (dt != 32'd0) && (dt < {16'd0, cfg.max_gap_ms});
  assign pause_exceed = dt > {16'd0, cfg.pause_ms};

  assign w  = clamp256(cfg.ema_weight);
  assign wc = 9'd256 - w;
  assign f  = clamp256(cfg.friction_factor);

  assign v_m    = (cmd.mlane == LANE_Y) ? vy_r : vx_r;
  assign v_a    = (cmd.alane == LANE_Y) ? vy_r : vx_r;
  assign inst_m = (cmd.mlane == LANE_Y) ? inst_y_r : inst_x_r;
  assign dist_m = (cmd.mlane == LANE_Y) ? dist_y_r : dist_x_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mop)
      MOP_INST_W: begin
        mul_a = 31'(inst_m);
        mul_b = {22'd0, w};
      end
      MOP_V_WC: begin
        mul_a = 31'(v_m);
        mul_b = {22'd0, wc};
      end
      MOP_V_V: begin
        mul_a = 31'(v_m);
        mul_b = 31'(v_m);
      end
      MOP_MIN: begin
        mul_a = {12'd0, cfg.min_speed};
        mul_b = {12'd0, cfg.min_speed};
      end
      MOP_CAP2: begin
        mul_a = {12'd0, cfg.cap_speed};
        mul_b = {12'd0, cfg.cap_speed};
      end
      MOP_V_CAP: begin
        mul_a = 31'(v_m);
        mul_b = {12'd0, cfg.cap_speed};
      end
      MOP_V_TK: begin
        mul_a = 31'(v_m);
        mul_b = {23'd0, cfg.tick_ms};
      end
      MOP_V_F: begin
        mul_a = 31'(v_m);
        mul_b = {22'd0, f};
      end
      MOP_D_D: begin
        mul_a = dist_m;
        mul_b = dist_m;
      end
      MOP_SD: begin
        mul_a = {14'd0, cfg.stop_distance};
        mul_b = {14'd0, cfg.stop_distance};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sum_ap = acc_r + prod_r;
  assign ema_v  = div256_tz(sum_ap);
  assign fric_v = div256_tz(prod_r);

  always_comb begin
    if (div_q > DIVN_W'(VEL_SAT)) begin
      inst_sat = VEL_SAT;
    end else if (div_q < -DIVN_W'(VEL_SAT)) begin
      inst_sat = -VEL_SAT;
    end else begin
      inst_sat = div_q[VEL_W-1:0];
    end
  end

  always_comb begin
    if (prod_r > OUT_MAX) begin
      outd = OUT_MAX[OUT_W-1:0];
    end else if (prod_r < OUT_MIN) begin
      outd = OUT_MIN[OUT_W-1:0];
    end else begin
      outd = prod_r[OUT_W-1:0];
    end
  end

  // Position delta of the lane being divided, scaled by 4096.
  assign dpos       = (cmd.alane == LANE_Y) ? (21'(py_r) - 21'(ly_r))
                                            : (21'(px_r) - 21'(lx_r));
  assign div_start  = (cmd.act == ACT_DIV_MOVE) || (cmd.act == ACT_DIV_CAP);
  assign div_num    = (cmd.act == ACT_DIV_CAP) ? prod_r[DIVN_W-1:0]
                                               : {{10{dpos[20]}}, dpos, 12'd0};
  assign div_den    = (cmd.act == ACT_DIV_CAP) ? sqrt_root : {6'd0, dt[15:0]};
  assign sqrt_start = (cmd.act == ACT_SQRT);

  ift_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .quotient (div_q)
  );

  ift_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (ssq_r[RAD_W-1:0]),
    .busy     (sqrt_busy),
    .root     (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (cmd.mop != MOP_NONE) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.acc == ACC_LOAD) begin
      acc_r <= prod_r;
    end
  end

  // Control state: the flags and the items that they guard.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drag_r  <= 1'b0;
      glide_r <= 1'b0;
      vx_r    <= '0;
      vy_r    <= '0;
      lx_r    <= '0;
      ly_r    <= '0;
      lt_r    <= '0;
    end else begin
      unique case (cmd.act)
        ACT_PRESS: begin
          glide_r <= 1'b0;
          if (left_r) begin
            drag_r <= 1'b1;
            lx_r   <= px_r;
            ly_r   <= py_r;
            lt_r   <= t_r;
            vx_r   <= '0;
            vy_r   <= '0;
          end
        end
        ACT_SET_LAST: begin
          lx_r <= px_r;
          ly_r <= py_r;
          lt_r <= t_r;
        end
        ACT_EMA: begin
          if (cmd.alane == LANE_Y) vy_r <= ema_v;
          else vx_r <= ema_v;
        end
        ACT_REL: begin
          drag_r <= 1'b0;
          if (pause_exceed) begin
            vx_r <= '0;
            vy_r <= '0;
          end
        end
        ACT_VCAP: begin
          if (cmd.alane == LANE_Y) vy_r <= div_q[VEL_W-1:0];
          else vx_r <= div_q[VEL_W-1:0];
        end
        ACT_FRIC: begin
          if (cmd.alane == LANE_Y) vy_r <= fric_v;
          else vx_r <= fric_v;
        end
        ACT_GLIDE_ON:  glide_r <= 1'b1;
        ACT_GLIDE_OFF: glide_r <= 1'b0;
        ACT_CMP_STOP: begin
          if (ssq_r < prod_r[SSQ_W-1:0]) glide_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Event latch and scratch registers.
  always_ff @(posedge clk) begin
    unique case (cmd.act)
      ACT_LOAD: begin
        op_r    <= op_t'(operation);
        px_r    <= pos_x;
        py_r    <= pos_y;
        t_r     <= time_ms;
        left_r  <= left_button;
        shift_r <= shift_held;
        map_r   <= map_present;
        mv_r    <= 1'b0;
        dx_r    <= '0;
        dy_r    <= '0;
      end
      ACT_INST: begin
        if (cmd.alane == LANE_Y) inst_y_r <= inst_sat;
        else inst_x_r <= inst_sat;
      end
      ACT_SSQ:     ssq_r <= SSQ_W'(sum_ap);
      ACT_CMP_MIN: above_min_r <= ssq_r > prod_r[SSQ_W-1:0];
      ACT_CMP_CAP: above_cap_r <= ssq_r > prod_r[SSQ_W-1:0];
      ACT_OUTD: begin
        mv_r <= 1'b1;
        if (cmd.alane == LANE_Y) dy_r <= outd;
        else dx_r <= outd;
      end
      ACT_DIST: begin
        if (cmd.alane == LANE_Y) dist_y_r <= prod_r[30:0];
        else dist_x_r <= prod_r[30:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status.op        = op_r;
    status.drag      = drag_r;
    status.glide     = glide_r;
    status.left      = left_r;
    status.shift     = shift_r;
    status.map       = map_r;
    status.gap_ok    = gap_ok;
    status.above_min = above_min_r;
    status.above_cap = above_cap_r;
    status.div_busy  = div_busy;
    status.sqrt_busy = sqrt_busy;
  end

  assign move_valid = mv_r;
  assign move_dx    = dx_r;
  assign move_dy    = dy_r;
  assign gliding    = glide_r;

  // A glide only starts from a release, and a press always ends it.
  a_glide_no_drag: assert property (@(posedge clk) disable iff (!rst_n)
    glide_r |-> !drag_r) else $error("glide active during a drag");

  a_vel_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vx_r <= VEL_SAT) && (vx_r >= -VEL_SAT) && (vy_r <= VEL_SAT) && (vy_r >= -VEL_SAT))
    else $error("velocity outside the saturation range");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider restarted while busy");

  a_sqrt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_start |-> !sqrt_busy) else $error("square root restarted while busy");

endmodule

`default_nettype wire

// ===== sv/ift_ctrl.sv =====
// ----------------------------------------------------------------------------
// ift_ctrl
// Sequencer: steps the datapath through the work of one event.
// ----------------------------------------------------------------------------
`default_nettype none

module ift_ctrl
  import ift_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_fire,
  input  wire logic    out_free,
  input  wire status_t status,
  output logic         in_ready,
  output cmd_t         cmd
);

  st_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.act   = ACT_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status.op)
          OP_PRESS: begin
            cmd.act   = ACT_PRESS;
            state_nxt = S_FIN;
          end
          OP_MOVE: begin
            if (status.drag && status.left && !status.shift) begin
              if (status.gap_ok) begin
                state_nxt = S_MV_DIVX;
              end else begin
                cmd.act   = ACT_SET_LAST;
                state_nxt = S_FIN;
              end
            end else begin
              state_nxt = S_FIN;
            end
          end
          OP_RELEASE: begin
            if (status.left && status.drag) begin
              cmd.act   = ACT_REL;
              state_nxt = S_RL_0;
            end else begin
              state_nxt = S_FIN;
            end
          end
          OP_TICK: begin
            if (status.glide && status.map) begin
              state_nxt = S_TK_0;
            end else begin
              if (status.glide) cmd.act = ACT_GLIDE_OFF;
              state_nxt = S_FIN;
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end

      // Move: instant velocity per lane, then the moving average.
      S_MV_DIVX: begin
        cmd.act   = ACT_DIV_MOVE;
        cmd.alane = LANE_X;
        state_nxt = S_MV_WX;
      end
      S_MV_WX: begin
        if (!status.div_busy) begin
          cmd.act   = ACT_INST;
          cmd.alane = LANE_X;
          state_nxt = S_MV_DIVY;
        end
      end
      S_MV_DIVY: begin
        cmd.act   = ACT_DIV_MOVE;
        cmd.alane = LANE_Y;
        state_nxt = S_MV_WY;
      end
      S_MV_WY: begin
        if (!status.div_busy) begin
          cmd.act   = ACT_INST;
          cmd.alane = LANE_Y;
          state_nxt = S_MV_E0;
        end
      end
      S_MV_E0: begin
        cmd.mop   = MOP_INST_W;
        cmd.mlane = LANE_X;
        state_nxt = S_MV_E1;
      end
      S_MV_E1: begin
        cmd.mop   = MOP_V_WC;
        cmd.mlane = LANE_X;
        cmd.acc   = ACC_LOAD;
        state_nxt = S_MV_E2;
      end
      S_MV_E2: begin
        cmd.act   = ACT_EMA;
        cmd.alane = LANE_X;
        cmd.mop   = MOP_INST_W;
        cmd.mlane = LANE_Y;
        state_nxt = S_MV_E3;
      end
      S_MV_E3: begin
        cmd.mop   = MOP_V_WC;
        cmd.mlane = LANE_Y;
        cmd.acc   = ACC_LOAD;
        state_nxt = S_MV_E4;
      end
      S_MV_E4: begin
        cmd.act   = ACT_EMA;
        cmd.alane = LANE_Y;
        state_nxt = S_MV_E5;
      end
      S_MV_E5: begin
        cmd.act   = ACT_SET_LAST;
        state_nxt = S_FIN;
      end

      // Release: squared speed against the limits, then optional capping.
      S_RL_0: begin
        cmd.mop   = MOP_V_V;
        cmd.mlane = LANE_X;
        state_nxt = S_RL_1;
      end
      S_RL_1: begin
        cmd.mop   = MOP_V_V;
        cmd.mlane = LANE_Y;
        cmd.acc   = ACC_LOAD;
        state_nxt = S_RL_2;
      end
      S_RL_2: begin
        cmd.mop   = MOP_MIN;
        cmd.act   = ACT_SSQ;
        state_nxt = S_RL_3;
      end
      S_RL_3: begin
        cmd.mop   = MOP_CAP2;
        cmd.act   = ACT_CMP_MIN;
        state_nxt = S_RL_4;
      end
      S_RL_4: begin
        cmd.act   = ACT_CMP_CAP;
        state_nxt = S_RL_5;
      end
      S_RL_5: begin
        if (!status.above_min) begin
          state_nxt = S_FIN;
        end else if (!status.above_cap) begin
          cmd.act   = ACT_GLIDE_ON;
          state_nxt = S_FIN;
        end else begin
          cmd.act   = ACT_SQRT;
          state_nxt = S_RL_SQW;
        end
      end
      S_RL_SQW: begin
        if (!status.sqrt_busy) state_nxt = S_RL_C0;
      end
      S_RL_C0: begin
        cmd.mop   = MOP_V_CAP;
        cmd.mlane = LANE_X;
        state_nxt = S_RL_C1;
      end
      S_RL_C1: begin
        cmd.act   = ACT_DIV_CAP;
        state_nxt = S_RL_C2;
      end
      S_RL_C2: begin
        if (!status.div_busy) begin
          cmd.act   = ACT_VCAP;
          cmd.alane = LANE_X;
          state_nxt = S_RL_C3;
        end
      end
      S_RL_C3: begin
        cmd.mop   = MOP_V_CAP;
        cmd.mlane = LANE_Y;
        state_nxt = S_RL_C4;
      end
      S_RL_C4: begin
        cmd.act   = ACT_DIV_CAP;
        state_nxt = S_RL_C5;
      end
      S_RL_C5: begin
        if (!status.div_busy) begin
          cmd.act   = ACT_VCAP;
          cmd.alane = LANE_Y;
          state_nxt = S_RL_C6;
        end
      end
      S_RL_C6: begin
        cmd.act   = ACT_GLIDE_ON;
        state_nxt = S_FIN;
      end

      // Tick: pan delta, friction, then the stop test on the new velocity.
      S_TK_0: begin
        cmd.mop   = MOP_V_TK;
        cmd.mlane = LANE_X;
        state_nxt = S_TK_1;
      end
      S_TK_1: begin
        cmd.mop   = MOP_V_TK;
        cmd.mlane = LANE_Y;
        cmd.act   = ACT_OUTD;
        cmd.alane = LANE_X;
        state_nxt = S_TK_2;
      end
      S_TK_2: begin
        cmd.mop   = MOP_V_F;
        cmd.mlane = LANE_X;
        cmd.act   = ACT_OUTD;
        cmd.alane = LANE_Y;
        state_nxt = S_TK_3;
      end
      S_TK_3: begin
        cmd.mop   = MOP_V_F;
        cmd.mlane = LANE_Y;
        cmd.act   = ACT_FRIC;
        cmd.alane = LANE_X;
        state_nxt = S_TK_4;
      end
      S_TK_4: begin
        cmd.act   = ACT_FRIC;
        cmd.alane = LANE_Y;
        state_nxt = S_TK_5;
      end
      S_TK_5: begin
        cmd.mop   = MOP_V_TK;
        cmd.mlane = LANE_X;
        state_nxt = S_TK_6;
      end
      S_TK_6: begin
        cmd.mop   = MOP_V_TK;
        cmd.mlane = LANE_Y;
        cmd.act   = ACT_DIST;
        cmd.alane = LANE_X;
        state_nxt = S_TK_7;
      end
      S_TK_7: begin
        cmd.act   = ACT_DIST;
        cmd.alane = LANE_Y;
        state_nxt = S_TK_8;
      end
      S_TK_8: begin
        cmd.mop   = MOP_D_D;
        cmd.mlane = LANE_X;
        state_nxt = S_TK_9;
      end
      S_TK_9: begin
        cmd.mop   = MOP_D_D;
        cmd.mlane = LANE_Y;
        cmd.acc   = ACC_LOAD;
        state_nxt = S_TK_10;
      end
      S_TK_10: begin
        cmd.mop   = MOP_SD;
        cmd.act   = ACT_SSQ;
        state_nxt = S_TK_11;
      end
      S_TK_11: begin
        cmd.act   = ACT_CMP_STOP;
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (out_free) begin
          cmd.done  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/inertial_fling_tracker.sv =====
// ----------------------------------------------------------------------------
// inertial_fling_tracker
// Kinetic scrolling: velocity tracking from pointer events, glide on release.
// ----------------------------------------------------------------------------
// Usage: events (press, move, release, glide tick) enter on in_ch; every
// accepted event yields exactly one result on out_ch (pan delta, its valid
// flag, and whether a glide is active afterwards). Settings are written over
// the APB port; the user must write them only while no event is in flight,
// as the block does not enforce it. Reads return the stored values. One
// event is processed at a time and in_ch.ready is high only when the
// sequencer is idle. A sampled move runs two serial divides; a release with
// capping runs a square root and two divides. A finished result sits in the
// output register; if the receiver stalls, the next event is still taken and
// worked on, and it waits at its end until the output register frees up.
// After reset the settings hold their defaults, no drag or glide is active
// and the velocity is zero.
// ----------------------------------------------------------------------------
`default_nettype none

module inertial_fling_tracker
  import ift_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  ift_in_if.sink           in_ch,
  ift_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t    cfg_r;
  status_t status;
  cmd_t    cmd;
  logic    in_ready, in_fire, out_free, cfg_wr;
  logic    out_valid_r;
  logic    mv_r, gl_r;
  logic signed [OUT_W-1:0] dx_r, dy_r;
  logic    dp_mv, dp_gl;
  logic signed [OUT_W-1:0] dp_dx, dp_dy;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ema_weight      <= 9'd102;
      cfg_r.friction_factor <= 9'd243;
      cfg_r.min_speed       <= 19'd3277;
      cfg_r.cap_speed       <= 19'd393216;
      cfg_r.tick_ms         <= 8'd16;
      cfg_r.max_gap_ms      <= 16'd200;
      cfg_r.pause_ms        <= 16'd80;
      cfg_r.stop_distance   <= 17'd6554;
    end else if (cfg_wr) begin
      unique case (idx)
        REG_EMA_WEIGHT:    cfg_r.ema_weight      <= pwdata[8:0];
        REG_FRICTION:      cfg_r.friction_factor <= pwdata[8:0];
        REG_MIN_SPEED:     cfg_r.min_speed       <= pwdata[18:0];
        REG_CAP_SPEED:     cfg_r.cap_speed       <= pwdata[18:0];
        REG_TICK_MS:       cfg_r.tick_ms         <= pwdata[7:0];
        REG_MAX_GAP_MS:    cfg_r.max_gap_ms      <= pwdata[15:0];
        REG_PAUSE_MS:      cfg_r.pause_ms        <= pwdata[15:0];
        REG_STOP_DISTANCE: cfg_r.stop_distance   <= pwdata[16:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_EMA_WEIGHT:    prdata = {23'd0, cfg_r.ema_weight};
      REG_FRICTION:      prdata = {23'd0, cfg_r.friction_factor};
      REG_MIN_SPEED:     prdata = {13'd0, cfg_r.min_speed};
      REG_CAP_SPEED:     prdata = {13'd0, cfg_r.cap_speed};
      REG_TICK_MS:       prdata = {24'd0, cfg_r.tick_ms};
      REG_MAX_GAP_MS:    prdata = {16'd0, cfg_r.max_gap_ms};
      REG_PAUSE_MS:      prdata = {16'd0, cfg_r.pause_ms};
      REG_STOP_DISTANCE: prdata = {15'd0, cfg_r.stop_distance};
      default:           prdata = '0;
    endcase
  end

  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  ift_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  ift_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .cmd         (cmd),
    .operation   (in_ch.operation),
    .pos_x       (in_ch.pos_x),
    .pos_y       (in_ch.pos_y),
    .time_ms     (in_ch.time_ms),
    .left_button (in_ch.left_button),
    .shift_held  (in_ch.shift_held),
    .map_present (in_ch.map_present),
    .status      (status),
    .move_valid  (dp_mv),
    .move_dx     (dp_dx),
    .move_dy     (dp_dy),
    .gliding     (dp_gl)
  );

  // Output register: holds a result until the receiver takes the transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      mv_r <= dp_mv;
      dx_r <= dp_dx;
      dy_r <= dp_dy;
      gl_r <= dp_gl;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.move_valid = mv_r;
  assign out_ch.move_dx    = dx_r;
  assign out_ch.move_dy    = dy_r;
  assign out_ch.gliding    = gl_r;

endmodule

`default_nettype wire
